// ===== rtl/fpt_pkg.sv =====
// ----------------------------------------------------------------------------
// fpt_pkg
// Shared widths, reset values, register indexes and arithmetic unit settings
// for the fiber permeability tensor pipeline.
// ----------------------------------------------------------------------------
package fpt_pkg;

  // Field widths.
  localparam int FRAC_W     = 16;
  localparam int GAIN_W     = 48;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 48;

  // Reset value of the fraction limit (0.9 in Q0.16).
  localparam logic [FRAC_W-1:0] MAX_FRACTION_RST = 16'd58982;

  // Saturated value of every tensor term.
  localparam logic [GAIN_W-1:0] TERM_MAX = '1;

  // Digit width of the partial products and latency of the multiplier.
  localparam int MUL_DIG = 24;
  localparam int MUL_LAT = 3;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GAIN_DARCY_AXIAL    = 3'd0,
    CFG_GAIN_DARCY_INPLANE  = 3'd1,
    CFG_GAIN_DARCY_OUTPLANE = 3'd2,
    CFG_GAIN_FORCH_AXIAL    = 3'd3,
    CFG_GAIN_FORCH_INPLANE  = 3'd4,
    CFG_GAIN_FORCH_OUTPLANE = 3'd5,
    CFG_MAX_FRACTION        = 3'd6
  } cfg_idx_t;

endpackage

// ===== rtl/fpt_if.sv =====
// ----------------------------------------------------------------------------
// fpt channel interfaces
// Valid/ready channels for cell fractions, tensor results and register writes.
// ----------------------------------------------------------------------------

// Input channel: one fiber volume fraction per transaction.
interface fpt_in_if;
  logic                        valid;
  logic                        ready;
  logic [fpt_pkg::FRAC_W-1:0]  fraction;

  modport source (output valid, output fraction, input ready);
  modport sink   (input valid, input fraction, output ready);
endinterface

// Result channel: six tensor terms and the range flag per transaction.
interface fpt_out_if;
  logic                        valid;
  logic                        ready;
  logic [fpt_pkg::GAIN_W-1:0]  darcy_axial;
  logic [fpt_pkg::GAIN_W-1:0]  darcy_inplane;
  logic [fpt_pkg::GAIN_W-1:0]  darcy_outplane;
  logic [fpt_pkg::GAIN_W-1:0]  forch_axial;
  logic [fpt_pkg::GAIN_W-1:0]  forch_inplane;
  logic [fpt_pkg::GAIN_W-1:0]  forch_outplane;
  logic                        out_of_range;

  modport source (output valid, output darcy_axial, output darcy_inplane,
                  output darcy_outplane, output forch_axial, output forch_inplane,
                  output forch_outplane, output out_of_range, input ready);
  modport sink   (input valid, input darcy_axial, input darcy_inplane,
                  input darcy_outplane, input forch_axial, input forch_inplane,
                  input forch_outplane, input out_of_range, output ready);
endinterface

// Configuration write channel.
interface fpt_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [fpt_pkg::CFG_IDX_W-1:0]   index;
  logic [fpt_pkg::CFG_DATA_W-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/fpt_delay.sv =====
// ----------------------------------------------------------------------------
// fpt_delay
// Stallable delay line that keeps side data aligned with the arithmetic units.
// ----------------------------------------------------------------------------
module fpt_delay #(
  parameter int W = 8,
  parameter int N = 1
) (
  input  logic         clk,
  input  logic         en,
  input  logic [W-1:0] d,
  output logic [W-1:0] q
);

  logic [W-1:0] tap_r [N];

  // Shift one place per enabled cycle.
  always_ff @(posedge clk) begin
    if (en) begin
      tap_r[0] <= d;
      for (int i = 1; i < N; i++) begin
        tap_r[i] <= tap_r[i-1];
      end
    end
  end

  assign q = tap_r[N-1];

endmodule

// ===== rtl/fpt_mul.sv =====
// ----------------------------------------------------------------------------
// fpt_mul
// Pipelined wide multiplier: digit products, then row sums, then the total.
// ----------------------------------------------------------------------------
module fpt_mul #(
  parameter int WA  = 48,
  parameter int WB  = 32,
  parameter int DIG = fpt_pkg::MUL_DIG
) (
  input  logic             clk,
  input  logic             en,
  input  logic [WA-1:0]    a,
  input  logic [WB-1:0]    b,
  output logic [WA+WB-1:0] p
);

  localparam int NA  = (WA + DIG - 1) / DIG;
  localparam int NB  = (WB + DIG - 1) / DIG;
  localparam int WAP = NA * DIG;
  localparam int WBP = NB * DIG;
  localparam int WP  = WA + WB;

  logic [WAP-1:0]   a_pad;
  logic [WBP-1:0]   b_pad;
  logic [2*DIG-1:0] pp_r [NA][NB];
  logic [WP-1:0]    row_nxt [NA];
  logic [WP-1:0]    row_r [NA];
  logic [WP-1:0]    p_nxt;
  logic [WP-1:0]    p_r;

  assign a_pad = WAP'(a);
  assign b_pad = WBP'(b);

  // Stage 1: every digit by digit product.
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < NA; i++) begin
        for (int j = 0; j < NB; j++) begin
          pp_r[i][j] <= a_pad[i*DIG +: DIG] * b_pad[j*DIG +: DIG];
        end
      end
    end
  end

  // Stage 2: sum each row of partial products.
  always_comb begin
    for (int i = 0; i < NA; i++) begin
      row_nxt[i] = '0;
      for (int j = 0; j < NB; j++) begin
        row_nxt[i] = row_nxt[i] + (WP'(pp_r[i][j]) << (j * DIG));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      row_r <= row_nxt;
    end
  end

  // Stage 3: sum the rows.
  always_comb begin
    p_nxt = '0;
    for (int i = 0; i < NA; i++) begin
      p_nxt = p_nxt + (row_r[i] << (i * DIG));
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_r <= p_nxt;
    end
  end

  assign p = p_r;

endmodule

// ===== rtl/fpt_sqrt.sv =====
// ----------------------------------------------------------------------------
// fpt_sqrt
// Pipelined integer square root, one root bit per stage (floor result).
// ----------------------------------------------------------------------------
module fpt_sqrt #(
  parameter int WX = 64
) (
  input  logic              clk,
  input  logic              en,
  input  logic [WX-1:0]     x,
  output logic [WX/2-1:0]   root
);

  localparam int N  = WX / 2;
  localparam int WR = WX / 2;
  localparam int WM = WR + 2;

  logic [WM-1:0] rem_in  [N];
  logic [WR-1:0] root_in [N];
  logic [WX-1:0] x_in    [N];
  logic [WM-1:0] rem_r   [N];
  logic [WR-1:0] root_r  [N];
  logic [WX-1:0] x_r     [N];

  for (genvar k = 0; k < N; k++) begin : g_stage
    logic [WM+1:0] rem2;
    logic [WM+1:0] trial;
    logic          fits;

    // Stage inputs come from the port or the previous stage.
    if (k == 0) begin : g_first
      assign rem_in[k]  = '0;
      assign root_in[k] = '0;
      assign x_in[k]    = x;
    end else begin : g_next
      assign rem_in[k]  = rem_r[k-1];
      assign root_in[k] = root_r[k-1];
      assign x_in[k]    = x_r[k-1];
    end

    // Bring down two radicand bits and try the next root bit.
    assign rem2  = {rem_in[k], x_in[k][WX-1 -: 2]};
    assign trial = (WM + 2)'({root_in[k], 2'b01});
    assign fits  = rem2 >= trial;

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k]  <= fits ? WM'(rem2 - trial) : WM'(rem2);
        root_r[k] <= {root_in[k][WR-2:0], fits};
        x_r[k]    <= x_in[k] << 2;
      end
    end
  end

  assign root = root_r[N-1];

endmodule

// ===== rtl/fpt_div.sv =====
// ----------------------------------------------------------------------------
// fpt_div
// Pipelined restoring divider, one quotient bit per stage. The upper WD bits
// of the dividend must be below the divisor.
// ----------------------------------------------------------------------------
module fpt_div #(
  parameter int WD = 48,
  parameter int NQ = 48
) (
  input  logic             clk,
  input  logic             en,
  input  logic [WD+NQ-1:0] num,
  input  logic [WD-1:0]    den,
  output logic [NQ-1:0]    quo
);

  logic [WD-1:0] rem_in [NQ];
  logic [NQ-1:0] low_in [NQ];
  logic [NQ-1:0] quo_in [NQ];
  logic [WD-1:0] den_in [NQ];
  logic [WD-1:0] rem_r  [NQ];
  logic [NQ-1:0] low_r  [NQ];
  logic [NQ-1:0] quo_r  [NQ];
  logic [WD-1:0] den_r  [NQ];

  for (genvar k = 0; k < NQ; k++) begin : g_stage
    logic [WD:0] rem2;
    logic        fits;

    // Stage inputs come from the ports or the previous stage.
    if (k == 0) begin : g_first
      assign rem_in[k] = num[WD+NQ-1:NQ];
      assign low_in[k] = num[NQ-1:0];
      assign quo_in[k] = '0;
      assign den_in[k] = den;
    end else begin : g_next
      assign rem_in[k] = rem_r[k-1];
      assign low_in[k] = low_r[k-1];
      assign quo_in[k] = quo_r[k-1];
      assign den_in[k] = den_r[k-1];
    end

    // Shift in the next dividend bit and subtract when it fits.
    assign rem2 = {rem_in[k], low_in[k][NQ-1]};
    assign fits = rem2 >= {1'b0, den_in[k]};

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k] <= fits ? WD'(rem2 - {1'b0, den_in[k]}) : WD'(rem2);
        low_r[k] <= low_in[k] << 1;
        quo_r[k] <= {quo_in[k][NQ-2:0], fits};
        den_r[k] <= den_in[k];
      end
    end
  end

  assign quo = quo_r[NQ-1];

endmodule

// ===== rtl/fiber_permeability_tensor.sv =====
// ----------------------------------------------------------------------------
// fiber_permeability_tensor
// Darcy and Forchheimer resistance tensor diagonals from a fiber volume
// fraction, one cell per cycle unless the output stalls, through a fully pipelined datapath.
// ----------------------------------------------------------------------------
//  channel | direction | payload                                  | type
//  --------+-----------+------------------------------------------+-------------
//  in_ch   | sink      | fraction (Q0.16)                         | fpt_in_if
//  out_ch  | source    | six Q32.16 terms, out_of_range           | fpt_out_if
//  cfg_ch  | sink      | index (3 bits), data (48 bits)           | fpt_cfg_if
//
// One cell is accepted every cycle unless the pipeline holds. The latency is
// set by the first stage, the chain of two 32-stage square roots, the 49-stage
// reciprocal divider, two 3-stage multipliers and the output register.
// Reset clears the valid bits and loads the register reset values.
// When the output register holds an untaken result the whole pipeline holds;
// the input register still takes one cell if it is empty.
// ----------------------------------------------------------------------------
module fiber_permeability_tensor (
  input  logic   clk,
  input  logic   rst_n,
  fpt_in_if.sink   in_ch,
  fpt_out_if.source out_ch,
  fpt_cfg_if.sink  cfg_ch
);

  localparam int FW     = fpt_pkg::FRAC_W;
  localparam int GW     = fpt_pkg::GAIN_W;
  localparam int ML     = fpt_pkg::MUL_LAT;
  localparam int SQ_W   = 64;
  localparam int SQ_LAT = SQ_W / 2;
  localparam int AX_NQ  = 48;
  localparam int AX_WD  = 48;
  localparam int TR_NQ  = 49;
  localparam int TR_WD  = FW;
  localparam int T_AXP  = 1 + ML;
  localparam int T_AXQ  = T_AXP + AX_NQ;
  localparam int T_S    = 1 + SQ_LAT;
  localparam int T_U    = T_S + TR_NQ;
  localparam int T_W    = T_U + SQ_LAT;
  localparam int T_BW   = T_W + ML;
  localparam int T_END  = T_BW + ML;

  // Configuration registers.
  logic [GW-1:0] gain_da_r, gain_di_r, gain_do_r;
  logic [GW-1:0] gain_fa_r, gain_fi_r, gain_fo_r;
  logic [FW-1:0] max_frac_r;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_da_r  <= '0;
      gain_di_r  <= '0;
      gain_do_r  <= '0;
      gain_fa_r  <= '0;
      gain_fi_r  <= '0;
      gain_fo_r  <= '0;
      max_frac_r <= fpt_pkg::MAX_FRACTION_RST;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        fpt_pkg::CFG_GAIN_DARCY_AXIAL:    gain_da_r  <= cfg_ch.data;
        fpt_pkg::CFG_GAIN_DARCY_INPLANE:  gain_di_r  <= cfg_ch.data;
        fpt_pkg::CFG_GAIN_DARCY_OUTPLANE: gain_do_r  <= cfg_ch.data;
        fpt_pkg::CFG_GAIN_FORCH_AXIAL:    gain_fa_r  <= cfg_ch.data;
        fpt_pkg::CFG_GAIN_FORCH_INPLANE:  gain_fi_r  <= cfg_ch.data;
        fpt_pkg::CFG_GAIN_FORCH_OUTPLANE: gain_fo_r  <= cfg_ch.data;
        fpt_pkg::CFG_MAX_FRACTION:        max_frac_r <= cfg_ch.data[FW-1:0];
        default: ;
      endcase
    end
  end

  // Pipeline control: everything moves unless a result waits at the output.
  logic           out_valid_r;
  logic           en;
  logic           load0;
  logic [T_END:0] vld_r;
  logic [FW-1:0]  f0_r;

  assign en          = !out_valid_r || out_ch.ready;
  assign load0       = en || !vld_r[0];
  assign in_ch.ready = load0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (load0) begin
        vld_r[0] <= in_ch.valid;
      end
      if (en) begin
        vld_r[T_END:1] <= vld_r[T_END-1:0];
        out_valid_r    <= vld_r[T_END];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load0) begin
      f0_r <= in_ch.fraction;
    end
  end

  // Special cases, decided at the input register.
  logic [1:0] flags0, flags_end;

  assign flags0 = {f0_r >= max_frac_r, f0_r == '0};

  fpt_delay #(.W(2), .N(T_END)) u_dly_flags (
    .clk(clk), .en(en), .d(flags0), .q(flags_end)
  );

  // Stage 1: squares, m*f and the distance to the limit.
  logic [FW:0]     d0;
  logic [2*FW-1:0] f2_1_r;
  logic [2*FW+1:0] d2_1_r;
  logic [FW:0]     d_1_r;
  logic [2*FW-1:0] mf_1_r;
  logic [FW-1:0]   mmf_1_r;
  logic [FW-1:0]   f_1_r;

  assign d0 = (FW + 1)'(18'h10000 - {2'b00, f0_r});

  always_ff @(posedge clk) begin
    if (en) begin
      f2_1_r  <= f0_r * f0_r;
      d2_1_r  <= d0 * d0;
      d_1_r   <= d0;
      mf_1_r  <= max_frac_r * f0_r;
      mmf_1_r <= max_frac_r - f0_r;
      f_1_r   <= f0_r;
    end
  end

  // Stage 2: cube of the distance.
  logic [3*FW+2:0] d3_full;
  logic [AX_WD-1:0] d3_2_r, d3_axp;

  assign d3_full = d2_1_r * d_1_r;

  always_ff @(posedge clk) begin
    if (en) begin
      d3_2_r <= d3_full[AX_WD-1:0];
    end
  end

  fpt_delay #(.W(AX_WD), .N(T_AXP - 2)) u_dly_d3 (
    .clk(clk), .en(en), .d(d3_2_r), .q(d3_axp)
  );

  // Axial numerators: gain * f^2.
  logic [GW+2*FW-1:0] pda, pfa;

  fpt_mul #(.WA(GW), .WB(2*FW)) u_mul_da (
    .clk(clk), .en(en), .a(gain_da_r), .b(f2_1_r), .p(pda)
  );
  fpt_mul #(.WA(GW), .WB(2*FW)) u_mul_fa (
    .clk(clk), .en(en), .a(gain_fa_r), .b(f2_1_r), .p(pfa)
  );

  // Axial division by the cube; saturation is known from the top bits.
  logic [1:0]        ax_sat, ax_sat_q;
  logic [AX_NQ-1:0]  qda, qfa;
  logic [2*GW-1:0]   ax_val, ax_end;

  assign ax_sat = {pfa >= {d3_axp, 32'b0}, pda >= {d3_axp, 32'b0}};

  fpt_div #(.WD(AX_WD), .NQ(AX_NQ)) u_div_da (
    .clk(clk), .en(en), .num({pda, 16'b0}), .den(d3_axp), .quo(qda)
  );
  fpt_div #(.WD(AX_WD), .NQ(AX_NQ)) u_div_fa (
    .clk(clk), .en(en), .num({pfa, 16'b0}), .den(d3_axp), .quo(qfa)
  );
  fpt_delay #(.W(2), .N(AX_NQ)) u_dly_axsat (
    .clk(clk), .en(en), .d(ax_sat), .q(ax_sat_q)
  );

  assign ax_val = {ax_sat_q[1] ? fpt_pkg::TERM_MAX : qfa,
                   ax_sat_q[0] ? fpt_pkg::TERM_MAX : qda};

  fpt_delay #(.W(2*GW), .N(T_END - T_AXQ)) u_dly_ax (
    .clk(clk), .en(en), .d(ax_val), .q(ax_end)
  );

  // Transverse: sqrt(m*f) in Q.32.
  logic [SQ_LAT-1:0] s_root;
  logic [2*FW-1:0]   fm_s;

  fpt_sqrt #(.WX(SQ_W)) u_sqrt_mf (
    .clk(clk), .en(en), .x({mf_1_r, 32'b0}), .root(s_root)
  );
  fpt_delay #(.W(2*FW), .N(T_S - 1)) u_dly_fm (
    .clk(clk), .en(en), .d({f_1_r, mmf_1_r}), .q(fm_s)
  );

  // Reciprocal u = (f + sqrt(m*f)) / (m - f) in Q.32.
  logic [32:0]      q_den;
  logic [TR_NQ-1:0] u_q;

  assign q_den = {1'b0, fm_s[2*FW-1:FW], 16'b0} + {1'b0, s_root};

  fpt_div #(.WD(TR_WD), .NQ(TR_NQ)) u_div_u (
    .clk(clk), .en(en), .num({16'b0, q_den, 16'b0}), .den(fm_s[FW-1:0]), .quo(u_q)
  );

  // sqrt(u) and u^2 side by side.
  logic [SQ_LAT-1:0]    w_root;
  logic [2*TR_NQ-1:0]   uu;
  logic [2*TR_NQ-33:0]  b_w;

  fpt_sqrt #(.WX(SQ_W)) u_sqrt_u (
    .clk(clk), .en(en), .x({1'b0, u_q, 14'b0}), .root(w_root)
  );
  fpt_mul #(.WA(TR_NQ), .WB(TR_NQ)) u_mul_uu (
    .clk(clk), .en(en), .a(u_q), .b(u_q), .p(uu)
  );
  fpt_delay #(.W(2*TR_NQ - 32), .N(T_W - T_U - ML)) u_dly_b (
    .clk(clk), .en(en), .d(uu[2*TR_NQ-1:32]), .q(b_w)
  );

  // u^2.5 = (u^2 >> 32) * sqrt(u) >> 23.
  localparam int BW_W   = 2*TR_NQ - 32 + SQ_LAT;
  localparam int BASE_W = BW_W - 23;
  logic [BW_W-1:0] bw;

  fpt_mul #(.WA(2*TR_NQ - 32), .WB(SQ_LAT)) u_mul_bw (
    .clk(clk), .en(en), .a(b_w), .b(w_root), .p(bw)
  );

  // Transverse terms: gain * u^2.5 >> 32, saturated.
  localparam int TP_W = BASE_W + GW;
  logic [TP_W-1:0] pdi, pdo, pfi, pfo;

  fpt_mul #(.WA(BASE_W), .WB(GW)) u_mul_di (
    .clk(clk), .en(en), .a(bw[BW_W-1:23]), .b(gain_di_r), .p(pdi)
  );
  fpt_mul #(.WA(BASE_W), .WB(GW)) u_mul_do (
    .clk(clk), .en(en), .a(bw[BW_W-1:23]), .b(gain_do_r), .p(pdo)
  );
  fpt_mul #(.WA(BASE_W), .WB(GW)) u_mul_fi (
    .clk(clk), .en(en), .a(bw[BW_W-1:23]), .b(gain_fi_r), .p(pfi)
  );
  fpt_mul #(.WA(BASE_W), .WB(GW)) u_mul_fo (
    .clk(clk), .en(en), .a(bw[BW_W-1:23]), .b(gain_fo_r), .p(pfo)
  );

  function automatic logic [GW-1:0] sat_term(input logic [TP_W-1:0] p);
    if (p[TP_W-1:GW+32] != '0) begin
      return fpt_pkg::TERM_MAX;
    end
    return p[GW+31:32];
  endfunction

  // Output register with the special cases applied.
  logic [GW-1:0] out_da_r, out_di_r, out_do_r, out_fa_r, out_fi_r, out_fo_r;
  logic          out_oor_r;

  always_ff @(posedge clk) begin
    if (en) begin
      out_oor_r <= flags_end[1];
      priority if (flags_end[1]) begin
        out_da_r <= fpt_pkg::TERM_MAX;
        out_di_r <= fpt_pkg::TERM_MAX;
        out_do_r <= fpt_pkg::TERM_MAX;
        out_fa_r <= fpt_pkg::TERM_MAX;
        out_fi_r <= fpt_pkg::TERM_MAX;
        out_fo_r <= fpt_pkg::TERM_MAX;
      end else if (flags_end[0]) begin
        out_da_r <= '0;
        out_di_r <= '0;
        out_do_r <= '0;
        out_fa_r <= '0;
        out_fi_r <= '0;
        out_fo_r <= '0;
      end else begin
        out_da_r <= ax_end[GW-1:0];
        out_di_r <= sat_term(pdi);
        out_do_r <= sat_term(pdo);
        out_fa_r <= ax_end[2*GW-1:GW];
        out_fi_r <= sat_term(pfi);
        out_fo_r <= sat_term(pfo);
      end
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.darcy_axial    = out_da_r;
  assign out_ch.darcy_inplane  = out_di_r;
  assign out_ch.darcy_outplane = out_do_r;
  assign out_ch.forch_axial    = out_fa_r;
  assign out_ch.forch_inplane  = out_fi_r;
  assign out_ch.forch_outplane = out_fo_r;
  assign out_ch.out_of_range   = out_oor_r;

endmodule
